@@ sv/assert_macros.svh @@
// Assertion macros shared by the index manager RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RBIM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RBIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rbim_pkg.sv @@
// Types and constants of the ring buffer index manager.
// No dependencies; used by the modulo unit and the top level.
package rbim_pkg;

  localparam int unsigned IDX_W     = 16;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned CNT_W     = 5;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 17'd65536;

  localparam logic [1:0] OP_QUERY     = 2'd0;
  localparam logic [1:0] OP_ADV_READ  = 2'd1;
  localparam logic [1:0] OP_ADV_WRITE = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_AVAIL,
    ST_SPLIT
  } state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] advance_length;
  } rbim_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] read_offset;
    logic [IDX_W-1:0] read_first_len;
    logic [IDX_W-1:0] read_second_len;
    logic [IDX_W-1:0] write_offset;
    logic [IDX_W-1:0] write_first_len;
    logic [IDX_W-1:0] write_second_len;
  } rbim_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] buffer_size;
  } rbim_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/rbim_stream_if.sv @@
// Valid/ready channel with a typed payload.
// Payload types come from rbim_pkg at the point of instantiation.
interface rbim_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rbim_mod_unit.sv @@
// Restoring remainder unit: one quotient bit per cycle over 17 steps.
// Depends on rbim_pkg for widths and the status struct.
module rbim_mod_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rbim_pkg::SIZE_W-1:0]      dividend,
  input  logic [rbim_pkg::SIZE_W-1:0]      divisor,
  output rbim_pkg::div_stat_t              stat,
  output logic [rbim_pkg::IDX_W-1:0]       remainder
);

  logic                          busy_r;
  logic                          done_r;
  logic [rbim_pkg::CNT_W-1:0]    cnt_r;
  logic [rbim_pkg::SIZE_W-1:0]   rem_r;
  logic [rbim_pkg::SIZE_W-1:0]   rem_nxt;
  logic [rbim_pkg::SIZE_W-1:0]   dvd_r;
  logic [rbim_pkg::SIZE_W-1:0]   dvs_r;
  logic [rbim_pkg::SIZE_W:0]     shifted;
  logic [rbim_pkg::SIZE_W:0]     trial;

  // shift in the next dividend bit, keep the difference when no borrow
  always_comb begin
    shifted = {rem_r, dvd_r[rbim_pkg::SIZE_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    rem_nxt = trial[rbim_pkg::SIZE_W] ? shifted[rbim_pkg::SIZE_W-1:0]
                                      : trial[rbim_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rbim_pkg::CNT_W'(rbim_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[rbim_pkg::SIZE_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  // remainder stays below the divisor, which never exceeds 65536
  assign remainder = rem_r[rbim_pkg::IDX_W-1:0];

endmodule

@@ sv/ring_buffer_index_manager_core.sv @@
// Ring buffer index manager: read/write indices of a circular byte buffer.
// Depends on rbim_pkg, rbim_stream_if, rbim_mod_unit and assert_macros.svh.
//
// Usage:
//   cfg_chan  - one transfer writes buffer_size (0 acts as 1, larger than the
//               cap saturates) and clears both indices. Taken only while idle.
//   in_chan   - one transfer carries an operation (query, advance read,
//               advance write, clear) and an advance length.
//   out_chan  - one transfer per input item: both indices and the readable
//               and writable regions, each split into a run at the index and
//               a run that wraps to offset zero.
// Items are handled one at a time. An advance goes through the shared
// 17-step restoring remainder unit; a query or a clear skips it and goes
// straight to the avail stage.
// The output register parts the two sides: the next item is taken while a
// result still waits; a finished item holds in the split stage until the
// receiver frees the output register.
// Reset: size goes to the cap (65536 by default), both indices to zero, no
// result pending.
module ring_buffer_index_manager_core #(
  parameter longint unsigned MAX_BUFFER_BYTES = 65536
) (
  input  logic  clk,
  input  logic  rst_n,
  rbim_stream_if.sink   in_chan,
  rbim_stream_if.source out_chan,
  rbim_stream_if.sink   cfg_chan
);

  `include "assert_macros.svh"

  localparam logic [rbim_pkg::SIZE_W-1:0] SIZE_CAP =
    (MAX_BUFFER_BYTES > 64'd65536) ? rbim_pkg::SIZE_LIMIT
                                   : rbim_pkg::SIZE_W'(MAX_BUFFER_BYTES);

  rbim_pkg::state_t                 state_r;
  rbim_pkg::state_t                 state_nxt;
  logic [rbim_pkg::SIZE_W-1:0]      size_r;
  logic [rbim_pkg::SIZE_W-1:0]      size_nxt;
  logic [rbim_pkg::IDX_W-1:0]       rd_idx_r;
  logic [rbim_pkg::IDX_W-1:0]       wr_idx_r;
  logic [1:0]                       op_r;
  logic                             out_valid_r;
  rbim_pkg::rbim_out_t              out_data_r;

  // region registers filled in the avail stage
  logic [rbim_pkg::SIZE_W-1:0]      ravail_r;
  logic [rbim_pkg::SIZE_W-1:0]      wavail_r;
  logic [rbim_pkg::SIZE_W-1:0]      rroom_r;
  logic [rbim_pkg::SIZE_W-1:0]      wroom_r;
  logic [rbim_pkg::SIZE_W-1:0]      ravail_nxt;
  logic [rbim_pkg::SIZE_W-1:0]      wavail_nxt;
  logic [rbim_pkg::SIZE_W-1:0]      r17;
  logic [rbim_pkg::SIZE_W-1:0]      w17;

  logic                             in_xfer;
  logic                             cfg_xfer;
  logic                             adv_op;
  logic                             div_start;
  logic                             out_load;
  logic [rbim_pkg::SIZE_W-1:0]      div_dividend;
  rbim_pkg::div_stat_t              div_stat;
  logic [rbim_pkg::IDX_W-1:0]       div_rem;
  rbim_pkg::rbim_out_t              out_nxt;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign cfg_xfer = cfg_chan.valid && cfg_chan.ready;
  assign adv_op   = (in_chan.data.operation == rbim_pkg::OP_ADV_READ) ||
                    (in_chan.data.operation == rbim_pkg::OP_ADV_WRITE);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbim_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = adv_op ? rbim_pkg::ST_DIV : rbim_pkg::ST_AVAIL;
        end
      end
      rbim_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = rbim_pkg::ST_AVAIL;
        end
      end
      rbim_pkg::ST_AVAIL: begin
        state_nxt = rbim_pkg::ST_SPLIT;
      end
      rbim_pkg::ST_SPLIT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = rbim_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rbim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready  = 1'b0;
    cfg_chan.ready = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      rbim_pkg::ST_IDLE: begin
        // a size write goes first; hold the input item until it is done
        in_chan.ready  = !cfg_chan.valid;
        cfg_chan.ready = 1'b1;
        div_start      = in_chan.valid && !cfg_chan.valid && adv_op;
      end
      rbim_pkg::ST_DIV:   ;
      rbim_pkg::ST_AVAIL: ;
      rbim_pkg::ST_SPLIT: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- remainder unit
  // dividend is the selected index plus the length; at most 17 bits
  assign div_dividend =
    ((in_chan.data.operation == rbim_pkg::OP_ADV_READ) ? {1'b0, rd_idx_r}
                                                       : {1'b0, wr_idx_r}) +
    {1'b0, in_chan.data.advance_length};

  rbim_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (size_r),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // --------------------------------------------------------------- size clamp
  always_comb begin
    priority if (cfg_chan.data.buffer_size == '0) begin
      size_nxt = rbim_pkg::SIZE_W'(1);
    end else if (cfg_chan.data.buffer_size > SIZE_CAP) begin
      size_nxt = SIZE_CAP;
    end else begin
      size_nxt = cfg_chan.data.buffer_size;
    end
  end

  // ---------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbim_pkg::ST_IDLE;
      size_r      <= SIZE_CAP;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      op_r        <= rbim_pkg::OP_QUERY;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a size change restarts both indices
      if (cfg_xfer) begin
        size_r   <= size_nxt;
        rd_idx_r <= '0;
        wr_idx_r <= '0;
      end
      if (in_xfer) begin
        op_r <= in_chan.data.operation;
        if (in_chan.data.operation == rbim_pkg::OP_CLEAR) begin
          rd_idx_r <= '0;
          wr_idx_r <= '0;
        end
      end
      // write back the wrapped index when the remainder is ready
      if (state_r == rbim_pkg::ST_DIV && div_stat.done) begin
        if (op_r == rbim_pkg::OP_ADV_READ) begin
          rd_idx_r <= div_rem;
        end else begin
          wr_idx_r <= div_rem;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- region math
  assign r17 = {1'b0, rd_idx_r};
  assign w17 = {1'b0, wr_idx_r};

  // readable bytes and free bytes, one slot always kept free
  always_comb begin
    ravail_nxt = (w17 >= r17) ? (w17 - r17) : (w17 + size_r - r17);
    priority if (w17 > r17) begin
      wavail_nxt = r17 + size_r - w17 - rbim_pkg::SIZE_W'(1);
    end else if (w17 < r17) begin
      wavail_nxt = r17 - w17 - rbim_pkg::SIZE_W'(1);
    end else begin
      wavail_nxt = size_r - rbim_pkg::SIZE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rbim_pkg::ST_AVAIL) begin
      ravail_r <= ravail_nxt;
      wavail_r <= wavail_nxt;
      rroom_r  <= size_r - r17;
      wroom_r  <= size_r - w17;
    end
  end

  // split each region at the buffer end
  always_comb begin
    out_nxt.read_offset  = rd_idx_r;
    out_nxt.write_offset = wr_idx_r;
    if (ravail_r > rroom_r) begin
      out_nxt.read_first_len  = rroom_r[rbim_pkg::IDX_W-1:0];
      out_nxt.read_second_len = rbim_pkg::IDX_W'(ravail_r - rroom_r);
    end else begin
      out_nxt.read_first_len  = ravail_r[rbim_pkg::IDX_W-1:0];
      out_nxt.read_second_len = '0;
    end
    if (wavail_r > wroom_r) begin
      out_nxt.write_first_len  = wroom_r[rbim_pkg::IDX_W-1:0];
      out_nxt.write_second_len = rbim_pkg::IDX_W'(wavail_r - wroom_r);
    end else begin
      out_nxt.write_first_len  = wavail_r[rbim_pkg::IDX_W-1:0];
      out_nxt.write_second_len = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // ---------------------------------------------------------------- checks
  `RBIM_ASSERT_NOW(a_idx_below_size, clk, rst_n, 1'b1, (r17 < size_r) && (w17 < size_r), "index reached buffer size")
  `RBIM_ASSERT_NOW(a_regions_fill, clk, rst_n, state_r == rbim_pkg::ST_SPLIT, (rbim_pkg::SIZE_W'(ravail_r + wavail_r) == rbim_pkg::SIZE_W'(size_r - rbim_pkg::SIZE_W'(1))), "regions do not cover buffer less one slot")
  `RBIM_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_stat.done, state_r == rbim_pkg::ST_DIV, "remainder finished outside divide step")
  `RBIM_ASSERT_NEXT(a_item_leaves_idle, clk, rst_n, in_xfer, state_r != rbim_pkg::ST_IDLE, "accepted item did not start")

endmodule
